// ===== rtl/kbs_pkg.sv =====
package kbs_pkg;

   localparam int unsigned SAT_W = 69;

   localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
   localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
   localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [4:0] CORDIC_LAST = 5'd29;
   localparam logic [5:0] DIV_LAST    = 6'd47;
   localparam logic [5:0] MUL_LAST    = 6'd33;

   localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] S32_MIN = 32'sh80000000;

   localparam logic OP_LOAD = 1'b1;

   localparam logic [2:0] REG_TIME_STEP     = 3'd0;
   localparam logic [2:0] REG_INV_WHEELBASE = 3'd1;
   localparam logic [2:0] REG_TOP_SPEED     = 3'd2;
   localparam logic [2:0] REG_LEAST_SPEED   = 3'd3;
   localparam logic [2:0] REG_SPEED_UP      = 3'd4;
   localparam logic [2:0] REG_SLOW_DOWN     = 3'd5;
   localparam logic [2:0] REG_STEER_LIMIT   = 3'd6;
   localparam logic [2:0] REG_STEER_STEP    = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLAMP, ST_RATE, ST_MID, ST_TRIG, ST_MOD, ST_WRAP, ST_FOLD, ST_ROT,
      ST_TAN, ST_DIV, ST_TANFIX, ST_MULLOAD, ST_MUL, ST_MULFIX, ST_UPDATE, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MS_VMC, MS_XDT, MS_VMS, MS_YDT, MS_VWB, MS_TAN, MS_HDT
   } mstep_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] r;
      unique case (idx)
         5'd0:  r = 30'd843314856;
         5'd1:  r = 30'd497837829;
         5'd2:  r = 30'd263043836;
         5'd3:  r = 30'd133525158;
         5'd4:  r = 30'd67021686;
         5'd5:  r = 30'd33543515;
         5'd6:  r = 30'd16775850;
         5'd7:  r = 30'd8388437;
         5'd8:  r = 30'd4194282;
         5'd9:  r = 30'd2097149;
         5'd10: r = 30'd1048575;
         5'd11: r = 30'd524287;
         5'd12: r = 30'd262143;
         5'd13: r = 30'd131071;
         5'd14: r = 30'd65535;
         5'd15: r = 30'd32767;
         5'd16: r = 30'd16383;
         5'd17: r = 30'd8191;
         5'd18: r = 30'd4095;
         5'd19: r = 30'd2047;
         5'd20: r = 30'd1023;
         5'd21: r = 30'd511;
         5'd22: r = 30'd255;
         5'd23: r = 30'd127;
         5'd24: r = 30'd63;
         5'd25: r = 30'd31;
         5'd26: r = 30'd15;
         5'd27: r = 30'd8;
         5'd28: r = 30'd4;
         5'd29: r = 30'd2;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_W'(S32_MAX)) r = S32_MAX;
      else if (v < SAT_W'(S32_MIN)) r = S32_MIN;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] clamp_speed(input logic signed [31:0] v,
                                                      input logic signed [31:0] lo,
                                                      input logic [30:0] hi);
      logic signed [32:0] r;
      logic signed [32:0] hs;
      hs = signed'({2'b00, hi});
      r = 33'(v);
      if (r < 33'(lo)) r = 33'(lo);
      if (r > hs) r = hs;
      return r[31:0];
   endfunction

   function automatic logic signed [31:0] rate_limit(input logic signed [31:0] cur,
                                                     input logic signed [31:0] tgt,
                                                     input logic [30:0] lim);
      logic signed [33:0] d;
      logic signed [33:0] m;
      logic signed [33:0] s;
      d = 34'(tgt) - 34'(cur);
      m = signed'({3'b000, lim});
      if (d > m) d = m;
      else if (d < -m) d = -m;
      s = 34'(cur) + d;
      return s[31:0];
   endfunction

endpackage

// ===== rtl/kinematic_bicycle_step_core.sv =====
// Kinematic bicycle step core. Each request is either a load (tuser high: set pose and clamped
// speed, clear steering) whose response is valid in the cycle after the transfer, or a
// simulation step: two angle reductions by a restoring division and CORDIC rotations of 30
// iterations, one restoring division for the tangent (skipped when the cosine is zero), and seven
// products on a bit-serial multiplier with set-up and fix-up, all in shared units. One
// request is in flight at a time; a new request is taken once the response has been transferred.
// Configuration writes are taken any cycle.
module kinematic_bicycle_step_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // velocity_command, steering_command, load_x, load_y, load_heading, load_velocity
   input  logic [191:0] req_tdata,
   // operation
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, out_heading, out_velocity, out_steering
   output logic [159:0] rsp_tdata,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import kbs_pkg::*;

   state_type state_ff, state_in;
   mstep_type mstep_ff, mstep_in;

   logic [30:0] dt_ff, dt_in, iwb_ff, iwb_in, vmax_ff, vmax_in;
   logic [30:0] accel_ff, accel_in, decel_ff, decel_in, srate_ff, srate_in;
   logic signed [31:0] vmin_ff, vmin_in;
   logic [16:0] slim_ff, slim_in;

   logic signed [31:0] px_ff, px_in, py_ff, py_in, hd_ff, hd_in, sp_ff, sp_in, st_ff, st_in;
   logic signed [31:0] vcmd_ff, vcmd_in, scmd_ff, scmd_in, tv_ff, tv_in, ts_ff, ts_in;
   logic signed [31:0] nv_ff, nv_in, ns_ff, ns_in, vm_ff, vm_in, sm_ff, sm_in;
   logic phase_ff, phase_in, flip_ff, flip_in, qneg_ff, qneg_in, pneg_ff, pneg_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [47:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [34:0] cz_ff, cz_in;
   logic signed [33:0] trig_c_ff, trig_c_in, trig_s_ff, trig_s_in;
   logic signed [31:0] tan_ff, tan_in, d_ff, d_in;
   logic [33:0] mc_ff, mc_in;
   logic [67:0] prod_ff, prod_in;
   logic signed [33:0] t_ff, t_in;
   logic signed [49:0] a_ff, a_in, b_ff, b_in;

   logic req_xfer;
   assign req_xfer = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = (req_tuser == OP_LOAD) ? ST_OUT : ST_CLAMP;
         ST_CLAMP:   state_in = ST_RATE;
         ST_RATE:    state_in = ST_MID;
         ST_MID:     state_in = ST_TRIG;
         ST_TRIG:    state_in = ST_MOD;
         ST_MOD:     if (cnt_ff == DIV_LAST) state_in = ST_WRAP;
         ST_WRAP:    state_in = ST_FOLD;
         ST_FOLD:    state_in = ST_ROT;
         ST_ROT:     if (cnt_ff[4:0] == CORDIC_LAST) state_in = phase_ff ? ST_MULLOAD : ST_TAN;
         ST_TAN:     state_in = (trig_c_ff == '0) ? ST_TRIG : ST_DIV;
         ST_DIV:     if (cnt_ff == DIV_LAST) state_in = ST_TANFIX;
         ST_TANFIX:  state_in = ST_TRIG;
         ST_MULLOAD: state_in = ST_MUL;
         ST_MUL:     if (cnt_ff == MUL_LAST) state_in = ST_MULFIX;
         ST_MULFIX:  state_in = (mstep_ff == MS_HDT) ? ST_UPDATE : ST_MULLOAD;
         ST_UPDATE:  state_in = ST_OUT;
         ST_OUT:     if (rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
   end

   assign rsp_tdata = {st_ff, sp_ff, hd_ff, py_ff, px_ff};

   always_comb begin
      logic signed [32:0] ang, smag, slo;
      logic [33:0] trial;
      logic q;
      logic signed [34:0] z, at;
      logic signed [33:0] sx, sy, nx, ny, oa, ob;
      logic [34:0] add;
      logic signed [SAT_W-1:0] sprod, sh30, sh16;

      dt_in = dt_ff; iwb_in = iwb_ff; vmax_in = vmax_ff; vmin_in = vmin_ff;
      accel_in = accel_ff; decel_in = decel_ff; slim_in = slim_ff; srate_in = srate_ff;
      px_in = px_ff; py_in = py_ff; hd_in = hd_ff; sp_in = sp_ff; st_in = st_ff;
      vcmd_in = vcmd_ff; scmd_in = scmd_ff; tv_in = tv_ff; ts_in = ts_ff;
      nv_in = nv_ff; ns_in = ns_ff; vm_in = vm_ff; sm_in = sm_ff;
      phase_in = phase_ff; flip_in = flip_ff; qneg_in = qneg_ff; pneg_in = pneg_ff;
      cnt_in = cnt_ff; dvd_in = dvd_ff; quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      trig_c_in = trig_c_ff; trig_s_in = trig_s_ff; tan_in = tan_ff; d_in = d_ff;
      mc_in = mc_ff; prod_in = prod_ff; t_in = t_ff; a_in = a_ff; b_in = b_ff;
      mstep_in = mstep_ff;

      ang = phase_ff ? 33'(hd_ff) : 33'(sm_ff);
      smag = ang[32] ? -ang : ang;
      slo = signed'({16'd0, slim_ff});
      trial = {rem_ff, dvd_ff[47]};
      q = (trial >= {1'b0, dvs_ff});
      z = 35'(0);
      at = signed'(35'(atan_q30(cnt_ff[4:0])));
      sx = cx_ff >>> cnt_ff[4:0];
      sy = cy_ff >>> cnt_ff[4:0];
      if (!cz_ff[34]) begin
         nx = cx_ff - sy;
         ny = cy_ff + sx;
      end else begin
         nx = cx_ff + sy;
         ny = cy_ff - sx;
      end
      oa = 34'(vm_ff);
      ob = trig_c_ff;
      unique case (mstep_ff)
         MS_VMC: begin oa = 34'(vm_ff); ob = trig_c_ff; end
         MS_XDT: begin oa = t_ff; ob = signed'({3'b000, dt_ff}); end
         MS_VMS: begin oa = 34'(vm_ff); ob = trig_s_ff; end
         MS_YDT: begin oa = t_ff; ob = signed'({3'b000, dt_ff}); end
         MS_VWB: begin oa = 34'(vm_ff); ob = signed'({3'b000, iwb_ff}); end
         MS_TAN: begin oa = 34'(d_ff); ob = 34'(tan_ff); end
         MS_HDT: begin oa = 34'(d_ff); ob = signed'({3'b000, dt_ff}); end
         default: begin oa = 34'(vm_ff); ob = trig_c_ff; end
      endcase
      add = {1'b0, prod_ff[67:34]} + (prod_ff[0] ? {1'b0, mc_ff} : 35'd0);
      sprod = signed'({1'b0, prod_ff});
      if (pneg_ff) sprod = -sprod;
      sh30 = sprod >>> 30;
      sh16 = sprod >>> 16;

      if (csr_wen) begin
         unique case (csr_index)
            REG_TIME_STEP:     dt_in = csr_wdata[30:0];
            REG_INV_WHEELBASE: iwb_in = csr_wdata[30:0];
            REG_TOP_SPEED:     vmax_in = csr_wdata[30:0];
            REG_LEAST_SPEED:   vmin_in = signed'(csr_wdata);
            REG_SPEED_UP:      accel_in = csr_wdata[30:0];
            REG_SLOW_DOWN:     decel_in = csr_wdata[30:0];
            REG_STEER_LIMIT:   slim_in = csr_wdata[16:0];
            REG_STEER_STEP:    srate_in = csr_wdata[30:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               phase_in = 1'b0;
               mstep_in = MS_VMC;
               if (req_tuser == OP_LOAD) begin
                  px_in = signed'(req_tdata[95:64]);
                  py_in = signed'(req_tdata[127:96]);
                  hd_in = signed'(req_tdata[159:128]);
                  sp_in = clamp_speed(signed'(req_tdata[191:160]), vmin_ff, vmax_ff);
                  st_in = '0;
               end else begin
                  vcmd_in = signed'(req_tdata[31:0]);
                  scmd_in = signed'(req_tdata[63:32]);
               end
            end
         end
         ST_CLAMP: begin
            tv_in = clamp_speed(vcmd_ff, vmin_ff, vmax_ff);
            if (33'(scmd_ff) < -slo) ts_in = 32'(-slo);
            else if (33'(scmd_ff) > slo) ts_in = 32'(slo);
            else ts_in = scmd_ff;
         end
         ST_RATE: begin
            nv_in = rate_limit(sp_ff, tv_ff, (tv_ff >= sp_ff) ? accel_ff : decel_ff);
            ns_in = rate_limit(st_ff, ts_ff, srate_ff);
         end
         ST_MID: begin
            vm_in = 32'((33'(sp_ff) + 33'(nv_ff)) >>> 1);
            sm_in = 32'((33'(st_ff) + 33'(ns_ff)) >>> 1);
         end
         ST_TRIG: begin
            dvd_in = {2'b00, smag[31:0], 14'd0};
            dvs_in = Q30_TWO_PI[32:0];
            rem_in = '0;
            qneg_in = ang[32];
            cnt_in = '0;
         end
         ST_MOD, ST_DIV: begin
            rem_in = q ? 33'(trial - {1'b0, dvs_ff}) : trial[32:0];
            quo_in = {quo_ff[46:0], q};
            dvd_in = {dvd_ff[46:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
         end
         ST_WRAP: begin
            z = signed'({2'b00, rem_ff});
            if (qneg_ff) z = -z;
            if (z > Q30_PI) z = z - Q30_TWO_PI;
            else if (z < -Q30_PI) z = z + Q30_TWO_PI;
            cz_in = z;
         end
         ST_FOLD: begin
            flip_in = 1'b0;
            if (cz_ff > Q30_HALF_PI) begin
               cz_in = cz_ff - Q30_PI;
               flip_in = 1'b1;
            end else if (cz_ff < -Q30_HALF_PI) begin
               cz_in = cz_ff + Q30_PI;
               flip_in = 1'b1;
            end
            cx_in = CORDIC_GAIN;
            cy_in = '0;
            cnt_in = '0;
         end
         ST_ROT: begin
            cx_in = nx;
            cy_in = ny;
            cz_in = cz_ff[34] ? cz_ff + at : cz_ff - at;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[4:0] == CORDIC_LAST) begin
               trig_c_in = flip_ff ? -nx : nx;
               trig_s_in = flip_ff ? -ny : ny;
            end
         end
         ST_TAN: begin
            if (trig_c_ff == '0) begin
               tan_in = trig_s_ff[33] ? S32_MIN : S32_MAX;
               phase_in = 1'b1;
            end else begin
               sx = trig_s_ff[33] ? -trig_s_ff : trig_s_ff;
               sy = trig_c_ff[33] ? -trig_c_ff : trig_c_ff;
               dvd_in = {sx[31:0], 16'd0};
               dvs_in = sy[32:0];
               rem_in = '0;
               qneg_in = trig_s_ff[33] ^ trig_c_ff[33];
               cnt_in = '0;
            end
         end
         ST_TANFIX: begin
            sprod = signed'(SAT_W'(quo_ff));
            if (qneg_ff) sprod = -sprod;
            tan_in = sat32(sprod);
            phase_in = 1'b1;
         end
         ST_MULLOAD: begin
            mc_in = oa[33] ? unsigned'(-oa) : unsigned'(oa);
            prod_in = {34'd0, ob[33] ? unsigned'(-ob) : unsigned'(ob)};
            pneg_in = oa[33] ^ ob[33];
            cnt_in = '0;
         end
         ST_MUL: begin
            prod_in = {add, prod_ff[33:1]};
            cnt_in = cnt_ff + 6'd1;
         end
         ST_MULFIX: begin
            unique case (mstep_ff)
               MS_VMC, MS_VMS: t_in = sh30[33:0];
               MS_XDT:         a_in = sh16[49:0];
               MS_YDT:         b_in = sh16[49:0];
               default:        d_in = sat32(sh16);
            endcase
            if (mstep_ff != MS_HDT) mstep_in = mstep_type'(mstep_ff + 3'd1);
         end
         ST_UPDATE: begin
            px_in = sat32(SAT_W'(px_ff) + SAT_W'(a_ff));
            py_in = sat32(SAT_W'(py_ff) + SAT_W'(b_ff));
            hd_in = sat32(SAT_W'(hd_ff) + SAT_W'(d_ff));
            sp_in = nv_ff;
            st_in = ns_ff;
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mstep_ff <= MS_VMC;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
         dt_ff    <= 31'd655;
         iwb_ff   <= 31'd26214;
         vmax_ff  <= 31'd655360;
         vmin_ff  <= '0;
         accel_ff <= 31'd1310;
         decel_ff <= 31'd1966;
         slim_ff  <= 17'd34315;
         srate_ff <= 31'd655;
         px_ff    <= '0;
         py_ff    <= '0;
         hd_ff    <= '0;
         sp_ff    <= '0;
         st_ff    <= '0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         dt_ff    <= dt_in;
         iwb_ff   <= iwb_in;
         vmax_ff  <= vmax_in;
         vmin_ff  <= vmin_in;
         accel_ff <= accel_in;
         decel_ff <= decel_in;
         slim_ff  <= slim_in;
         srate_ff <= srate_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
         hd_ff    <= hd_in;
         sp_ff    <= sp_in;
         st_ff    <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      vcmd_ff <= vcmd_in;  scmd_ff <= scmd_in;
      tv_ff <= tv_in;      ts_ff <= ts_in;
      nv_ff <= nv_in;      ns_ff <= ns_in;
      vm_ff <= vm_in;      sm_ff <= sm_in;
      flip_ff <= flip_in;  qneg_ff <= qneg_in;  pneg_ff <= pneg_in;
      dvd_ff <= dvd_in;    quo_ff <= quo_in;    rem_ff <= rem_in;  dvs_ff <= dvs_in;
      cx_ff <= cx_in;      cy_ff <= cy_in;      cz_ff <= cz_in;
      trig_c_ff <= trig_c_in;  trig_s_ff <= trig_s_in;
      tan_ff <= tan_in;    d_ff <= d_in;
      mc_ff <= mc_in;      prod_ff <= prod_in;
      t_ff <= t_in;        a_ff <= a_in;        b_ff <= b_in;
   end

   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request and response sides busy together");

   a_load_resp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> rsp_tvalid && rsp_tdata[159:128] == 32'd0)
      else $error("load did not answer next cycle with cleared steering");

   a_rot_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROT |-> cnt_ff <= {1'b0, CORDIC_LAST})
      else $error("rotation count overrun");

   a_mulfix_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MULFIX |-> $past(state_ff) == ST_MUL)
      else $error("product fix-up without multiply");

endmodule
